// File: hdl/vbsf_pkg.sv
// Package: shared types and constants for the voxel box and sphere fill core.
package vbsf_pkg;

	// command modes
	typedef enum logic [1:0] {
		MODE_PLACE  = 2'd0,
		MODE_BOX    = 2'd1,
		MODE_SPHERE = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	localparam int CfgW = 6;
	localparam int CntW = 16;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

// File: hdl/voxel_box_and_sphere_fill_core.sv
// Top level: voxel store with single-cell place/read and box and sphere fill.
//
// A command is taken when start is high and busy is low; busy then stays high
// until the result word is shown on done for one cycle (no back-pressure).
// Place and read step from idle through one walk or read-wait state to the done
// state; a place outside the grid and a fill whose clipped box is empty go
// straight to done. Box and sphere fills walk the clipped bounding box one cell
// per cycle through the single store write port (at most MAX_X*MAX_Y*MAX_Z
// cells; a sphere walks the whole configured grid). After reset the store is
// cleared one cell per cycle with busy high; configuration writes are taken
// during that time.
module voxel_box_and_sphere_fill_core
	import vbsf_pkg::*;
#(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CfgW-1:0]        cfg_data,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             mode,
	input  logic signed [7:0]      corner_a_x,
	input  logic signed [7:0]      corner_a_y,
	input  logic signed [7:0]      corner_a_z,
	input  logic signed [7:0]      corner_b_x,
	input  logic signed [7:0]      corner_b_y,
	input  logic signed [7:0]      corner_b_z,
	input  logic [10:0]            sphere_radius,
	input  logic [7:0]             fill_value,
	output logic                   done,
	output logic [7:0]             read_value,
	output logic [CntW-1:0]        cells_written
);

	localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = AW + 1;

	// config registers
	logic [CfgW-1:0] size_x_q, size_y_q, size_z_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CfgW'(32);
			size_y_q <= CfgW'(32);
			size_z_q <= CfgW'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective grid extents, clamped to the store
	logic signed [9:0] nx, ny, nz;
	assign nx = (32'(size_x_q) > MAX_X) ? 10'(MAX_X) : 10'(size_x_q);
	assign ny = (32'(size_y_q) > MAX_Y) ? 10'(MAX_Y) : 10'(size_y_q);
	assign nz = (32'(size_z_q) > MAX_Z) ? 10'(MAX_Z) : 10'(size_z_q);

	state_t state_q, state_d;
	logic accept;
	assign accept = start && (state_q == ST_IDLE);

	// clipped box bounds from the command
	logic signed [9:0] ax, ay, az, bx, by, bz;
	logic signed [9:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	logic signed [9:0] cx0, cx1, cy0, cy1, cz0, cz1;
	logic box_empty, a_in;
	always_comb begin
		ax = 10'(corner_a_x); ay = 10'(corner_a_y); az = 10'(corner_a_z);
		bx = 10'(corner_b_x); by = 10'(corner_b_y); bz = 10'(corner_b_z);
		if (mode_t'(mode) == MODE_BOX) begin
			lo_x = (ax < bx) ? ax : bx; hi_x = (ax < bx) ? bx : ax;
			lo_y = (ay < by) ? ay : by; hi_y = (ay < by) ? by : ay;
			lo_z = (az < bz) ? az : bz; hi_z = (az < bz) ? bz : az;
		end else begin
			lo_x = '0; hi_x = nx - 10'sd1;
			lo_y = '0; hi_y = ny - 10'sd1;
			lo_z = '0; hi_z = nz - 10'sd1;
		end
		cx0 = (lo_x < 0) ? '0 : lo_x; cx1 = (hi_x > nx - 10'sd1) ? nx - 10'sd1 : hi_x;
		cy0 = (lo_y < 0) ? '0 : lo_y; cy1 = (hi_y > ny - 10'sd1) ? ny - 10'sd1 : hi_y;
		cz0 = (lo_z < 0) ? '0 : lo_z; cz1 = (hi_z > nz - 10'sd1) ? nz - 10'sd1 : hi_z;
		box_empty = (cx0 > cx1) || (cy0 > cy1) || (cz0 > cz1);
		a_in = (ax >= 0) && (ax < nx) && (ay >= 0) && (ay < ny)
			&& (az >= 0) && (az < nz);
	end

	// command registers
	mode_t             mode_q;
	logic [7:0]        val_q;
	logic signed [9:0] ax_q, ay_q, az_q;
	logic [21:0]       r2_q;
	logic [XW-1:0]     x1_q, x_q;
	logic [YW-1:0]     y0_q, y1_q, y_q;
	logic [ZW-1:0]     z0_q, z1_q, z_q;
	logic              hit_q;
	logic [CW-1:0]     clr_q;
	logic [CntW-1:0]   cnt_q;

	logic walk_last;
	assign walk_last = (x_q == x1_q) && (y_q == y1_q) && (z_q == z1_q);

	// sphere test on current cell: two stage free, narrow products
	logic signed [9:0] dx, dy, dz;
	logic signed [19:0] dxw, dyw, dzw;
	logic [19:0] d2;
	logic in_sphere;
	always_comb begin
		dx = 10'(signed'({1'b0, x_q})) - ax_q;
		dy = 10'(signed'({1'b0, y_q})) - ay_q;
		dz = 10'(signed'({1'b0, z_q})) - az_q;
		dxw = 20'(dx);
		dyw = 20'(dy);
		dzw = 20'(dz);
		d2 = dxw * dxw + dyw * dyw + dzw * dzw;
		in_sphere = (mode_q == MODE_SPHERE) ? ({d2, 8'd0} < {6'd0, r2_q}) : 1'b1;
	end

	// store write/read port
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr, cur_addr, a_addr;
	logic [7:0]    mem_wdata, mem_rdata_q;
	logic [7:0]    store [DEPTH];

	assign cur_addr = AW'((32'(x_q) * MAX_Y + 32'(y_q)) * MAX_Z + 32'(z_q));
	assign a_addr = AW'((32'(ax[XW-1:0]) * MAX_Y + 32'(ay[YW-1:0])) * MAX_Z
		+ 32'(az[ZW-1:0]));

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = val_q;
		mem_re = 1'b0;
		mem_raddr = a_addr;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q[AW-1:0];
				mem_wdata = '0;
			end
			ST_IDLE: mem_re = accept && (mode_t'(mode) == MODE_READ) && a_in;
			ST_WALK: mem_we = in_sphere;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) store[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= store[mem_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == CW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (mode_t'(mode))
						MODE_READ:  state_d = ST_RDWAIT;
						MODE_PLACE: state_d = a_in ? ST_WALK : ST_DONE;
						default:    state_d = box_empty ? ST_DONE : ST_WALK;
					endcase
				end
			end
			ST_WALK:   if (walk_last) state_d = ST_DONE;
			ST_RDWAIT: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		read_value = (mode_q == MODE_READ && hit_q) ? mem_rdata_q : '0;
		cells_written = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
		end
	end

	// command and walk counters; the count saturates
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			val_q  <= fill_value;
			ax_q <= ax; ay_q <= ay; az_q <= az;
			r2_q <= 22'(sphere_radius) * 22'(sphere_radius);
			hit_q <= a_in;
			cnt_q <= '0;
			if (mode_t'(mode) == MODE_PLACE) begin
				x1_q <= ax[XW-1:0]; x_q <= ax[XW-1:0];
				y0_q <= ay[YW-1:0]; y1_q <= ay[YW-1:0]; y_q <= ay[YW-1:0];
				z0_q <= az[ZW-1:0]; z1_q <= az[ZW-1:0]; z_q <= az[ZW-1:0];
			end else begin
				x1_q <= cx1[XW-1:0]; x_q <= cx0[XW-1:0];
				y0_q <= cy0[YW-1:0]; y1_q <= cy1[YW-1:0]; y_q <= cy0[YW-1:0];
				z0_q <= cz0[ZW-1:0]; z1_q <= cz1[ZW-1:0]; z_q <= cz0[ZW-1:0];
			end
		end else if (state_q == ST_WALK) begin
			if (in_sphere && (cnt_q != '1)) cnt_q <= cnt_q + CntW'(1);
			if (z_q != z1_q) begin
				z_q <= z_q + ZW'(1);
			end else begin
				z_q <= z0_q;
				if (y_q != y1_q) begin
					y_q <= y_q + YW'(1);
				end else begin
					y_q <= y0_q;
					x_q <= x_q + XW'(1);
				end
			end
		end
	end

endmodule
